/* hw/rtl/i2c_master_frame_receiver_assert.svh */
// Assertion macros for the I2C master frame receiver.
// Sampled on clk_i; disabled while rst_ni is low. No other dependencies.
`ifndef I2C_MASTER_FRAME_RECEIVER_ASSERT_SVH
`define I2C_MASTER_FRAME_RECEIVER_ASSERT_SVH

// Property checked at every clock edge.
`define I2CMFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define I2CMFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CMFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/i2cmfr_pkg.sv */
// Shared types and constants for the I2C master frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package i2cmfr_pkg;

  // Frame buffer depth of the attached system; bounds the byte index.
  localparam int FRAME_DEPTH = 128;

  // Highest byte index before the frame is forced to end.
  localparam logic [6:0] COUNT_LIMIT =
    7'((FRAME_DEPTH - 1 > 127) ? 127 : FRAME_DEPTH - 1);

  // Checksum bytes following the end marker.
  localparam logic [7:0] CHECKSUM_LEN = 8'd4;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_RECV = 3'd2;
  localparam logic [2:0] PH_ACK  = 3'd3;
  localparam logic [2:0] PH_STOP = 3'd4;

  // Bus action codes.
  localparam logic [2:0] ACT_ADDR = 3'd0;
  localparam logic [2:0] ACT_RECV = 3'd1;
  localparam logic [2:0] ACT_ACK  = 3'd2;
  localparam logic [2:0] ACT_STOP = 3'd3;
  localparam logic [2:0] ACT_NONE = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_END_MARKER = 2'd1;
  localparam logic [1:0] REG_MAX_INDEX  = 2'd2;

  typedef struct packed {
    logic       slave_nack;
    logic [7:0] rx_data;
  } in_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [6:0] byte_position;
    logic       frame_complete;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/i2cmfr_in_reg.sv */
// Input register of the I2C master frame receiver.
// Holds one accepted event beat; depends on i2cmfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmfr_in_reg
  import i2cmfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire in_t  in_data_i,
  output logic      in_stall_o,
  input  wire logic take_i,
  output logic      item_valid_o,
  output in_t       item_o
);

  logic valid_q;
  in_t  data_q;

  // Stall only while a held beat cannot move on.
  assign in_stall_o   = valid_q & ~take_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/i2cmfr_seq.sv */
// Phase sequencer and configuration registers of the I2C master frame receiver.
// Depends on i2cmfr_pkg and i2c_master_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_frame_receiver_assert.svh"

module i2cmfr_seq
  import i2cmfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_wr_t cfg_i,
  input  wire logic    advance_i,
  input  wire in_t     item_i,
  output out_t         result_o
);

  logic [7:0] slave_addr_q;
  logic [7:0] end_marker_q;
  logic [6:0] max_index_q;

  logic [2:0] phase_q,      phase_d;
  logic [6:0] byte_count_q, byte_count_d;
  logic       end_known_q,  end_known_d;
  logic [7:0] end_pos_q,    end_pos_d;
  logic       last_nack_q,  last_nack_d;
  logic       done_q,       done_d;
  logic       finish;

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    end_known_d  = end_known_q;
    end_pos_d    = end_pos_q;
    last_nack_d  = last_nack_q;
    done_d       = done_q;
    finish       = 1'b0;
    result_o     = '0;
    result_o.bus_action = ACT_NONE;

    unique case (phase_q)
      PH_IDLE: begin
        done_d              = 1'b0;
        result_o.bus_action = ACT_ADDR;
        result_o.tx_byte    = slave_addr_q;
        phase_d             = PH_ADDR;
      end
      PH_ADDR: begin
        // single ACK status check: a nack closes the transfer
        if (!item_i.slave_nack) begin
          result_o.bus_action = ACT_RECV;
          phase_d             = PH_RECV;
        end else begin
          result_o.bus_action = ACT_STOP;
          phase_d             = PH_STOP;
        end
      end
      PH_RECV: begin
        result_o.byte_valid    = 1'b1;
        result_o.byte_value    = item_i.rx_data;
        result_o.byte_position = byte_count_q;
        if (item_i.rx_data == end_marker_q) begin
          end_known_d = 1'b1;
          end_pos_d   = {1'b0, byte_count_q} + CHECKSUM_LEN;
        end
        finish = (end_known_d && ({1'b0, byte_count_q} == end_pos_d)) ||
                 (byte_count_q > max_index_q) ||
                 (byte_count_q >= COUNT_LIMIT);
        if (finish) begin
          done_d      = 1'b1;
          last_nack_d = 1'b1;
        end else begin
          byte_count_d = byte_count_q + 7'd1;
          last_nack_d  = 1'b0;
        end
        result_o.ack_bit    = last_nack_d;
        result_o.bus_action = ACT_ACK;
        phase_d             = PH_ACK;
      end
      PH_ACK: begin
        if (last_nack_q) begin
          result_o.bus_action = ACT_STOP;
          phase_d             = PH_STOP;
        end else begin
          result_o.bus_action = ACT_RECV;
          phase_d             = PH_RECV;
        end
      end
      default: begin
        // stop phase, and any stray code behaves the same
        phase_d      = PH_IDLE;
        byte_count_d = '0;
        end_known_d  = 1'b0;
      end
    endcase

    result_o.frame_complete = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd0;
      end_marker_q <= 8'd3;
      max_index_q  <= 7'd70;
      phase_q      <= PH_IDLE;
      byte_count_q <= '0;
      end_known_q  <= 1'b0;
      end_pos_q    <= '0;
      last_nack_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_SLAVE_ADDR: slave_addr_q <= cfg_i.data;
          REG_END_MARKER: end_marker_q <= cfg_i.data;
          REG_MAX_INDEX:  max_index_q  <= cfg_i.data[6:0];
          default: ;
        endcase
      end
      if (advance_i) begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
        end_known_q  <= end_known_d;
        end_pos_q    <= end_pos_d;
        last_nack_q  <= last_nack_d;
        done_q       <= done_d;
      end
    end
  end

  `I2CMFR_ASSERT(a_count_bounded, byte_count_q <= COUNT_LIMIT, "byte index past limit")
  `I2CMFR_ASSERT_IMPL(a_nack_ends_frame, result_o.ack_bit, result_o.frame_complete,
    "nack driven without frame end")
  `I2CMFR_ASSERT_IMPL(a_tx_only_addr, result_o.tx_byte != 8'd0,
    result_o.bus_action == ACT_ADDR, "tx byte outside address action")
  `I2CMFR_ASSERT_NEXT(a_stop_clears, advance_i && (phase_q >= PH_STOP),
    (byte_count_q == 7'd0) && !end_known_q && (phase_q == PH_IDLE),
    "stop event did not clear frame state")

endmodule

`default_nettype wire

/* hw/rtl/i2cmfr_out_reg.sv */
// Result register of the I2C master frame receiver.
// Holds one result beat until taken; depends on i2cmfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmfr_out_reg
  import i2cmfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  wire out_t res_i,
  output logic      take_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic valid_q;
  out_t data_q;

  // Free when empty or when the held beat leaves this cycle.
  assign take_o      = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_frame_receiver.sv */
// I2C master frame receiver: at most one bus action per bus-completion event.
// An accepted beat is held in the input register; its result beat is loaded into the
// result register when that is free, and leaves from there.
// Throughput: one event per cycle while the result channel does not stall; the phase
// update is computed between the input register and the result register.
// Reset (async, active low): phase idle, counters clear, registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_frame_receiver
  import i2cmfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // event channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_t        in_data_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_t            out_data_o,
  // configuration write channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic    take;        // result register can load this cycle
  logic    item_valid;  // input register holds an event
  in_t     item;
  logic    advance;     // event moves through the sequencer now
  out_t    result;
  cfg_wr_t cfg_wr;

  // Register writes never wait; they are meant for idle periods only.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // The sequencer state steps exactly when an event enters the result register.
  assign advance = item_valid & take;

  i2cmfr_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  i2cmfr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  // Result register: a finished beat waits here while the next event is taken.
  i2cmfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_i       (result),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
